// ===== hdl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the ultrasonic proximity detector.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_SAFE_DISTANCE = 2'd0;
  localparam logic [1:0] REG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_HOLD          = 2'd2;

  // Register reset values
  localparam logic [9:0]  SAFE_DISTANCE_RST = 10'd50;
  localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd50000;
  localparam logic [25:0] HOLD_RST          = 26'd1000000;

  // Trigger pulse shape, in ticks
  localparam logic [15:0] TRIG_LOW_TICKS  = 16'd2;
  localparam logic [15:0] TRIG_HIGH_TICKS = 16'd10;

  // Hold counter saturates here
  localparam logic [25:0] HOLD_MAX = 26'h3FFFFFF;

  // floor(w*17/1000) == (w * DIST_MULT) >> DIST_SHIFT for any 16-bit w
  localparam int          DIST_SHIFT = 26;
  localparam logic [20:0] DIST_MULT  = 21'd1140851;
  localparam logic [9:0]  DIST_MAX   = 10'd1023;

  // Live configuration
  typedef struct packed {
    logic [9:0]  safe_distance_cm;
    logic [15:0] echo_timeout_us;
    logic [25:0] hold_us;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       timed_out;
    logic [9:0] distance_cm;
    logic       reading_done;
    logic       detected;
    logic       trigger_out;
  } result_t;

endpackage

// ===== hdl/upd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// upd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module upd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [25:0]   cfg_data,
  output upd_pkg::cfg_t cfg
);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safe_distance_cm <= upd_pkg::SAFE_DISTANCE_RST;
      cfg.echo_timeout_us  <= upd_pkg::ECHO_TIMEOUT_RST;
      cfg.hold_us          <= upd_pkg::HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        upd_pkg::REG_SAFE_DISTANCE: cfg.safe_distance_cm <= cfg_data[9:0];
        upd_pkg::REG_ECHO_TIMEOUT:  cfg.echo_timeout_us  <= cfg_data[15:0];
        upd_pkg::REG_HOLD:          cfg.hold_us          <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/upd_core.sv =====
// ----------------------------------------------------------------------------
// upd_core
// Ranging sequencer and detection logic; one tick per step, result registered.
// ----------------------------------------------------------------------------
module upd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             echo,
  input  upd_pkg::cfg_t    cfg,
  output upd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_END,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  phase_t      phase, phase_next, ph_eff;
  logic [15:0] phase_count, phase_count_next;
  logic [15:0] pulse_width, pulse_width_next;
  logic [25:0] near_hold, near_hold_next, hold_inc;
  logic        detected_flag, detected_flag_next;
  upd_pkg::result_t res_next;

  logic [36:0] dist_prod;
  logic [10:0] dist_raw;
  logic [9:0]  dist_width;
  logic [9:0]  dist_sel;
  logic        finish;
  logic        tmo;

  // Distance of the current pulse width by reciprocal multiply
  assign dist_prod  = {21'd0, pulse_width} * {16'd0, upd_pkg::DIST_MULT};
  assign dist_raw   = dist_prod[upd_pkg::DIST_SHIFT +: 11];
  assign dist_width = dist_raw[10] ? upd_pkg::DIST_MAX : dist_raw[9:0];

  // Saturating ticks since the last near reading
  assign hold_inc = (near_hold == upd_pkg::HOLD_MAX) ? near_hold : near_hold + 26'd1;

  // Next-state logic for one tick
  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    pulse_width_next   = pulse_width;
    near_hold_next     = hold_inc;
    detected_flag_next = detected_flag;
    ph_eff             = phase;
    finish             = 1'b0;
    tmo                = 1'b0;
    dist_sel           = '0;
    res_next           = '0;

    unique case (phase) inside
      PH_TRIG_HIGH: begin
        res_next.trigger_out = 1'b1;
        phase_count_next     = phase_count + 16'd1;
        if (phase_count_next >= upd_pkg::TRIG_HIGH_TICKS) begin
          phase_next       = PH_WAIT_END;
          phase_count_next = '0;
          pulse_width_next = '0;
        end
      end
      PH_WAIT_END, PH_WAIT_RISE, PH_MEASURE: begin
        // a sample that ends one wait is seen at once by the next
        if (ph_eff == PH_WAIT_END && !echo) ph_eff = PH_WAIT_RISE;
        if (ph_eff == PH_WAIT_RISE && echo) ph_eff = PH_MEASURE;
        if (ph_eff == PH_MEASURE && !echo) begin
          finish   = 1'b1;
          dist_sel = dist_width;
        end else if (phase_count >= cfg.echo_timeout_us) begin
          finish = 1'b1;
          tmo    = 1'b1;
        end else begin
          phase_count_next = phase_count + 16'd1;
          phase_next       = ph_eff;
          if (ph_eff == PH_MEASURE) pulse_width_next = pulse_width + 16'd1;
        end
      end
      default: begin
        // trigger low, and recovery from any stray code
        phase_next       = PH_TRIG_LOW;
        phase_count_next = phase_count + 16'd1;
        if (phase_count_next >= upd_pkg::TRIG_LOW_TICKS) begin
          phase_next       = PH_TRIG_HIGH;
          phase_count_next = '0;
        end
      end
    endcase

    // Reading complete: update detection and restart the cycle
    if (finish) begin
      if (dist_sel < cfg.safe_distance_cm) begin
        detected_flag_next = 1'b1;
        near_hold_next     = '0;
      end else if (hold_inc > cfg.hold_us) begin
        detected_flag_next = 1'b0;
      end else begin
        detected_flag_next = 1'b1;
      end
      phase_next       = PH_TRIG_LOW;
      phase_count_next = '0;
      pulse_width_next = '0;
    end

    res_next.detected     = detected_flag_next;
    res_next.reading_done = finish;
    res_next.distance_cm  = dist_sel;
    res_next.timed_out    = tmo;
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TRIG_LOW;
      phase_count   <= '0;
      pulse_width   <= '0;
      near_hold     <= '0;
      detected_flag <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      pulse_width   <= pulse_width_next;
      near_hold     <= near_hold_next;
      detected_flag <= detected_flag_next;
    end
    if (step) res <= res_next;
  end

endmodule

// ===== hdl/ultrasonic_proximity_detector.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_proximity_detector
// Trigger/echo ranger, one input item per microsecond tick, with a
// hold-off detected flag.
// ----------------------------------------------------------------------------
//  channel  dir  signals                         item
//  s_*      in   tvalid tready tdata[7:0]        one tick: echo sample
//  m_*      out  tvalid tready tdata[15:0]       one result per tick
//  cfg_*    in   valid ready index[1:0] data     register write
//
//  One item per cycle sustained while the output is not stalled; an item passes
//  the input register, then the sequencer and result register, which holds a
//  multiply by the distance reciprocal and the near compare.
//  Reset clears the handshake state and restarts with the trigger low phase,
//  detected set and registers at their defaults.
//  A stalled output holds its item; the input register still takes one more.
//  The configuration channel is always ready.
// ----------------------------------------------------------------------------
module ultrasonic_proximity_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] echo, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] trigger_out, [1] detected, [2] reading_done,
                                 // [12:3] distance_cm, [13] timed_out, [15:14] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  upd_pkg::cfg_t    cfg;
  upd_pkg::result_t res;

  logic in_full;
  logic in_echo;
  logic advance;
  logic step;

  assign advance   = !m_tvalid || m_tready;
  assign step      = in_full && advance;
  assign s_tready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
    if (s_tready && s_tvalid) in_echo <= s_tdata[0];
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step;
    end
  end

  upd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  upd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .echo (in_echo),
    .cfg  (cfg),
    .res  (res)
  );

  assign m_tdata = {2'b00, res};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ultrasonic proximity detector. A short table of
// directed tick runs covers the trigger shape, the echo wait and measure
// phases, timeout at zero and at a short budget, registers at full scale and
// the hold extremes, then bursts of random readings run under changing
// register settings. Every result item is checked against a cycle-level
// predictor of the ranger sequence, or against a typed value on the directed
// rows.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_TICKS = 800;
  localparam int unsigned RANDOM_READINGS = 8;
  localparam int unsigned TRIG_LOW_LEN = 2;
  localparam int unsigned TRIG_HIGH_LEN = 10;
  localparam logic [25:0] HOLD_TOP = 26'h3FFFFFF;
  // Index past the register map, writes to it must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // Ranger sequence as seen by the predictor
  typedef enum logic [2:0] {
    ST_TRIG_LOW,
    ST_TRIG_HIGH,
    ST_ECHO_END,
    ST_ECHO_RISE,
    ST_ECHO_HIGH
  } ranger_state_e;

  typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_e;

  // One directed row: a register write, or a run of ticks at one echo level
  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       index;
    logic [25:0]      data;
    logic             echo;
    int unsigned      ticks;
    logic             typed;
    upd_pkg::result_t res;   // expected on the last tick when typed is set
  } row_t;

  localparam upd_pkg::result_t NO_RES = '0;

  // res fields: timed_out, distance_cm, reading_done, detected, trigger_out
  localparam row_t DIRECTED [0:23] = '{
    // first tick after reset
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 1, 1'b0, NO_RES},
    // echo high during the trigger pulse is ignored
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 10, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b1, 1'b1}},
    // stale echo, gap, 120 tick pulse -> 2 cm, near
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 5, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 3, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 120, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 1, 1'b1, '{1'b0, 10'd2, 1'b1, 1'b1, 1'b0}},
    // zero budget times out on the first wait tick, reads as near
    '{ROW_WRITE, upd_pkg::REG_ECHO_TIMEOUT, 26'd0, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 12, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 1, 1'b1, '{1'b1, 10'd0, 1'b1, 1'b1, 1'b0}},
    // safe distance 0 and hold 0: a timeout is far and clears detected
    '{ROW_WRITE, upd_pkg::REG_SAFE_DISTANCE, 26'd0, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_WRITE, upd_pkg::REG_HOLD, 26'd0, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 13, 1'b1, '{1'b1, 10'd0, 1'b1, 1'b0, 1'b0}},
    // unmapped index, then all registers at full scale
    '{ROW_WRITE, REG_UNMAPPED, '1, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_WRITE, upd_pkg::REG_ECHO_TIMEOUT, '1, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_WRITE, upd_pkg::REG_SAFE_DISTANCE, '1, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_WRITE, upd_pkg::REG_HOLD, '1, 1'b0, 0, 1'b0, NO_RES},
    // 250 tick pulse -> 4 cm, near against the full-scale safe distance
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 13, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b1, 250, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 1, 1'b1, '{1'b0, 10'd4, 1'b1, 1'b1, 1'b0}},
    // no echo at all: trigger, then a 40 tick budget, then timeout
    '{ROW_WRITE, upd_pkg::REG_ECHO_TIMEOUT, 26'd40, 1'b0, 0, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 52, 1'b0, NO_RES},
    '{ROW_TICKS, 2'd0, 26'd0, 1'b0, 1, 1'b1, '{1'b1, 10'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_WRITE, upd_pkg::REG_SAFE_DISTANCE, 26'd50, 1'b0, 0, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;

  // Predictor state and its copy of the registers
  ranger_state_e rng_state = ST_TRIG_LOW;
  logic [15:0]   rng_count = '0;
  logic [15:0]   rng_width = '0;
  logic [25:0]   since_near = '0;
  logic          det_flag = 1'b1;
  logic [9:0]    cfg_safe = upd_pkg::SAFE_DISTANCE_RST;
  logic [15:0]   cfg_timeout = upd_pkg::ECHO_TIMEOUT_RST;
  logic [25:0]   cfg_hold = upd_pkg::HOLD_RST;

  upd_pkg::result_t predicted_ticks [$];
  int unsigned readings_done = 0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 1;

  // Typed expectation for the next accepted item
  logic             typed_armed = 1'b0;
  upd_pkg::result_t typed_res = '0;

  // Echo plan for the random readings
  logic        plan_armed = 1'b0;
  logic        plan_noise = 1'b0;
  int unsigned plan_pre = 0;
  int unsigned plan_gap = 0;
  int unsigned plan_len = 0;

  ultrasonic_proximity_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One microsecond tick of the ranger: advance state, return the result item
  function automatic upd_pkg::result_t ranger_tick(input logic echo);
    upd_pkg::result_t r;
    logic             finish;
    logic [15:0]      width;
    int unsigned      range_cm;
    r = '0;
    finish = 1'b0;
    width = '0;
    if (since_near != HOLD_TOP) since_near++;
    case (rng_state)
      ST_TRIG_LOW: begin
        rng_count++;
        if (rng_count >= TRIG_LOW_LEN) begin
          rng_state = ST_TRIG_HIGH;
          rng_count = '0;
        end
      end
      ST_TRIG_HIGH: begin
        r.trigger_out = 1'b1;
        rng_count++;
        if (rng_count >= TRIG_HIGH_LEN) begin
          rng_state = ST_ECHO_END;
          rng_count = '0;
          rng_width = '0;
        end
      end
      default: begin
        // the sample that ends one wait is seen at once by the next phase
        if (rng_state == ST_ECHO_END && !echo) rng_state = ST_ECHO_RISE;
        if (rng_state == ST_ECHO_RISE && echo) rng_state = ST_ECHO_HIGH;
        if (rng_state == ST_ECHO_HIGH && !echo) begin
          finish = 1'b1;
          width = rng_width;
        end else if (rng_count >= cfg_timeout) begin
          finish = 1'b1;
          r.timed_out = 1'b1;
        end else begin
          rng_count++;
          if (rng_state == ST_ECHO_HIGH) rng_width++;
        end
      end
    endcase
    // reading complete: distance, near test, hold-off
    if (finish) begin
      range_cm = (32'(width) * 17) / 1000;
      if (range_cm > 1023) range_cm = 1023;
      if (range_cm < cfg_safe) begin
        det_flag = 1'b1;
        since_near = '0;
      end else begin
        det_flag = (since_near <= cfg_hold);
      end
      r.reading_done = 1'b1;
      r.distance_cm = range_cm[9:0];
      rng_state = ST_TRIG_LOW;
      rng_count = '0;
      rng_width = '0;
    end
    r.detected = det_flag;
    return r;
  endfunction

  // Echo level for the next random tick, steered by the predicted phase
  function automatic logic next_echo_level();
    if (rng_state == ST_TRIG_LOW || rng_state == ST_TRIG_HIGH) begin
      plan_armed = 1'b0;
      return 1'($urandom_range(0, 1));
    end
    if (!plan_armed) begin
      plan_armed = 1'b1;
      plan_noise = ($urandom_range(0, 7) == 0);
      plan_pre = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      plan_gap = $urandom_range(1, 6);
      plan_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 400)
                                             : $urandom_range(1, 60);
    end
    if (plan_noise) return 1'($urandom_range(0, 1));
    if (plan_pre != 0) begin
      plan_pre--;
      return 1'b1;
    end
    if (plan_gap != 0) begin
      plan_gap--;
      return 1'b0;
    end
    if (plan_len != 0) begin
      plan_len--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic log_mismatch(input string what, input upd_pkg::result_t want,
                              input upd_pkg::result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: trig %0d/%0d det %0d/%0d done %0d/%0d dist %0d/%0d tmo %0d/%0d",
               $realtime, what, want.trigger_out, got.trigger_out, want.detected,
               got.detected, want.reading_done, got.reading_done, want.distance_cm,
               got.distance_cm, want.timed_out, got.timed_out);
  endtask

  // Send one tick item, then maybe pause the sender between bursts
  task automatic send_tick(input logic planned, input logic echo_fixed,
                           input logic check_typed, input upd_pkg::result_t typed_val);
    logic echo;
    @(negedge clk);
    echo = planned ? next_echo_level() : echo_fixed;
    typed_armed = check_typed;
    typed_res = typed_val;
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, echo};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 40);
    end
  endtask

  // Register write once every predicted result has come back
  task automatic write_register(input logic [1:0] idx, input logic [25:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predicted_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      upd_pkg::REG_SAFE_DISTANCE: cfg_safe = value[9:0];
      upd_pkg::REG_ECHO_TIMEOUT:  cfg_timeout = value[15:0];
      upd_pkg::REG_HOLD:          cfg_hold = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Monitor: predict on each accepted tick, check each accepted result
  always @(posedge clk) begin
    upd_pkg::result_t want;
    upd_pkg::result_t got;
    logic             moved;
    moved = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = ranger_tick(s_tdata[0]);
        if (want.reading_done) readings_done++;
        if (typed_armed) begin
          want = typed_res;
          typed_armed = 1'b0;
        end
        predicted_ticks.push_back(want);
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = upd_pkg::result_t'(m_tdata[13:0]);
        if (predicted_ticks.size() == 0) begin
          log_mismatch("unexpected result", NO_RES, got);
        end else begin
          want = predicted_ticks.pop_front();
          if (got !== want) log_mismatch("result mismatch", want, got);
        end
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Receiver: free running, random stalls, or one item in three
  initial begin
    int unsigned mode;
    int unsigned n;
    forever begin
      mode = $urandom_range(0, 2);
      n = 0;
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= (n % 3 == 0);
        endcase
        n++;
      end
    end
  end

  // Watchdog: nothing accepted for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned rand_base;
    int unsigned reading_base;
    int unsigned target;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        write_register(DIRECTED[r].index, DIRECTED[r].data);
      end else begin
        for (int unsigned n = 0; n < DIRECTED[r].ticks; n++)
          send_tick(1'b0, DIRECTED[r].echo,
                    DIRECTED[r].typed && (n == DIRECTED[r].ticks - 1), DIRECTED[r].res);
      end
    end

    // random phases: new settings, then a few readings each
    rand_base = items_sent;
    reading_base = readings_done;
    while (items_sent - rand_base < RANDOM_TICKS
           || readings_done - reading_base < RANDOM_READINGS) begin
      case ($urandom_range(0, 7))
        0:       write_register(upd_pkg::REG_SAFE_DISTANCE, '0);
        1:       write_register(upd_pkg::REG_SAFE_DISTANCE, 26'd1023);
        2:       write_register(upd_pkg::REG_SAFE_DISTANCE, 26'($urandom));
        default: write_register(upd_pkg::REG_SAFE_DISTANCE, 26'($urandom_range(1, 4)));
      endcase
      case ($urandom_range(0, 7))
        0:       write_register(upd_pkg::REG_ECHO_TIMEOUT, '0);
        1:       write_register(upd_pkg::REG_ECHO_TIMEOUT, 26'd1);
        2:       write_register(upd_pkg::REG_ECHO_TIMEOUT, 26'($urandom_range(1000, 65535)));
        default: write_register(upd_pkg::REG_ECHO_TIMEOUT, 26'($urandom_range(20, 800)));
      endcase
      case ($urandom_range(0, 7))
        0:       write_register(upd_pkg::REG_HOLD, '0);
        1:       write_register(upd_pkg::REG_HOLD, HOLD_TOP);
        2:       write_register(upd_pkg::REG_HOLD, 26'($urandom));
        default: write_register(upd_pkg::REG_HOLD, 26'($urandom_range(0, 150)));
      endcase
      if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, 26'($urandom));
      target = readings_done + $urandom_range(2, 6);
      while (readings_done < target) send_tick(1'b1, 1'b0, 1'b0, NO_RES);
    end

    // drain and let the pipeline settle
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predicted_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/upd_pkg.sv
hdl/upd_cfg_regs.sv
hdl/upd_core.sv
hdl/ultrasonic_proximity_detector.sv
bench/testbench.sv
